// File: rtl/bfsp_pkg.sv
// Package for the bit file section parser: parser state, result record,
// phase codes, section kinds, status codes and the fixed header bytes.
// No dependencies.
`default_nettype none

package bfsp_pkg;

    // Number of fixed header bytes at the start of a bit file
    localparam logic [3:0] HEADER_LEN = 4'd13;

    // Section kinds ('a'..'e' map to 0..4)
    localparam logic [2:0] KIND_DESC      = 3'd0;
    localparam logic [2:0] KIND_BITSTREAM = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd5;

    // Section ID characters
    localparam logic [7:0] ID_FIRST = 8'h61;  // 'a'
    localparam logic [7:0] ID_LAST  = 8'h65;  // 'e'

    // Length field sizes in bytes
    localparam logic [2:0] LEN_BYTES_LONG  = 3'd4;
    localparam logic [2:0] LEN_BYTES_SHORT = 3'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_HEADER    = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_ID      = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_ERROR   = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  header_index;
        logic [2:0]  length_bytes_left;
        logic [2:0]  current_kind;
        logic [31:0] bytes_remaining;
        logic [4:0]  seen_sections;
        logic [1:0]  error_code;
    } t_state;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [2:0]  section_kind;
        logic        section_end;
        logic [31:0] section_length;
        logic        length_valid;
        logic        unknown_section;
        logic        file_done;
        logic [1:0]  status;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:             PH_HEADER,
        header_index:      4'd0,
        length_bytes_left: 3'd0,
        current_kind:      3'd0,
        bytes_remaining:   32'd0,
        seen_sections:     5'd0,
        error_code:        ST_OK
    };

    // Expected header byte at a given position
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h09;
            4'd2:    b = 8'h0f;
            4'd3:    b = 8'hf0;
            4'd4:    b = 8'h0f;
            4'd5:    b = 8'hf0;
            4'd6:    b = 8'h0f;
            4'd7:    b = 8'hf0;
            4'd8:    b = 8'h0f;
            4'd9:    b = 8'hf0;
            4'd10:   b = 8'h00;
            4'd11:   b = 8'h00;
            4'd12:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bfsp_if.sv
// Valid/ready channel interfaces for the bit file section parser:
// the byte input channel and the result channel. No dependencies.
`default_nettype none

interface bfsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface bfsp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [2:0]  section_kind;
    logic        section_end;
    logic [31:0] section_length;
    logic        length_valid;
    logic        unknown_section;
    logic        file_done;
    logic [1:0]  status;

    modport source (
        output valid, output payload_byte, output payload_valid, output section_kind,
        output section_end, output section_length, output length_valid,
        output unknown_section, output file_done, output status, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid, input section_kind,
        input section_end, input section_length, input length_valid,
        input unknown_section, input file_done, input status, output ready
    );
endinterface

`default_nettype wire

// File: rtl/bfsp_step.sv
// Next-state and result logic for one byte of the bit file parser.
// Depends on bfsp_pkg.
`default_nettype none

module bfsp_step (
    input  bfsp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    output bfsp_pkg::t_state  o_state,
    output bfsp_pkg::t_result o_result
);
    import bfsp_pkg::*;

    t_state      s;
    t_result     r;
    logic [2:0]  id_kind;
    logic        id_known;
    logic [31:0] len_shift;
    logic [2:0]  len_left;
    logic [31:0] pay_left;

    // Decode of the ID byte, shifted length and payload countdown
    always_comb begin
        id_known  = (i_byte >= ID_FIRST) && (i_byte <= ID_LAST);
        id_kind   = id_known ? 3'(i_byte - ID_FIRST) : KIND_UNKNOWN;
        len_shift = {i_state.bytes_remaining[23:0], i_byte};
        len_left  = (i_state.length_bytes_left != 3'd0) ?
                    i_state.length_bytes_left - 3'd1 : 3'd0;
        pay_left  = (i_state.bytes_remaining != 32'd0) ?
                    i_state.bytes_remaining - 32'd1 : 32'd0;
    end

    // Per-phase state update and result
    always_comb begin
        s = i_state;
        r = '0;
        unique case (i_state.phase)
            PH_HEADER: begin
                if (i_state.header_index >= HEADER_LEN ||
                    i_byte != magic_byte(i_state.header_index)) begin
                    s.phase = PH_ERROR;
                    if (i_state.error_code == ST_OK) s.error_code = ST_HEADER;
                end else begin
                    s.header_index = i_state.header_index + 4'd1;
                    if (s.header_index == HEADER_LEN) s.phase = PH_ID;
                end
            end
            PH_ID: begin
                s.current_kind = id_kind;
                if (id_known && i_state.seen_sections[id_kind]) begin
                    // repeated known section
                    s.phase = PH_ERROR;
                    if (i_state.error_code == ST_OK) s.error_code = ST_DUPLICATE;
                end else begin
                    if (id_known) s.seen_sections[id_kind] = 1'b1;
                    r.section_kind      = id_kind;
                    r.unknown_section   = !id_known;
                    s.length_bytes_left = (id_kind == KIND_BITSTREAM) ?
                                          LEN_BYTES_LONG : LEN_BYTES_SHORT;
                    s.bytes_remaining   = 32'd0;
                    s.phase             = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                r.section_kind      = i_state.current_kind;
                r.unknown_section   = (i_state.current_kind == KIND_UNKNOWN);
                s.bytes_remaining   = len_shift;
                s.length_bytes_left = len_left;
                if (len_left == 3'd0) begin
                    r.section_length = len_shift;
                    r.length_valid   = 1'b1;
                    if (len_shift == 32'd0) begin
                        r.section_end = 1'b1;
                        s.phase       = PH_ID;
                    end else begin
                        s.phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.section_kind    = i_state.current_kind;
                r.unknown_section = (i_state.current_kind == KIND_UNKNOWN);
                if (i_state.current_kind != KIND_UNKNOWN) begin
                    r.payload_byte  = i_byte;
                    r.payload_valid = 1'b1;
                end
                s.bytes_remaining = pay_left;
                if (pay_left == 32'd0) begin
                    r.section_end = 1'b1;
                    s.phase       = PH_ID;
                end
            end
            PH_ERROR: begin
                s.phase = PH_ERROR;
            end
            default: begin
                s.phase = PH_ERROR;
            end
        endcase

        // End of file: flag truncation, report, then return to reset
        if (i_eos) begin
            if (s.phase != PH_ID && s.phase != PH_ERROR) begin
                s.phase = PH_ERROR;
                if (s.error_code == ST_OK) s.error_code = ST_TRUNCATED;
            end
            r.file_done = 1'b1;
        end
        r.status = s.error_code;

        o_result = r;
        o_state  = i_eos ? STATE_RESET : s;
    end

endmodule

`default_nettype wire

// File: rtl/bit_file_section_parser.sv
// Top level of the bit file section parser: parser state register,
// result register and handshakes. Depends on bfsp_pkg, bfsp_if, bfsp_step.
`default_nettype none

// Bit file section parser. Takes one byte of an FPGA bit file per accepted
// item and gives exactly one result item per byte from a result register. It
// checks the 13-byte fixed header, then walks the sections (ID byte,
// big-endian length of 4 bytes for 'e' and 2 bytes otherwise, payload),
// passing payload bytes of sections 'a'..'e' with their kind and marking
// the last byte of each section. Unknown sections are skipped and flagged.
// Status is sticky within a file: header mismatch, truncated file or
// duplicate section. The byte marked end_of_stream carries file_done and
// the final status, and the parser then starts over for the next file.
// Throughput is one byte per clock: the whole update of the parser state
// is one short combinational step between the state register and the
// result register, and a new byte is taken whenever the result register
// is empty or its result is being taken in the same cycle.
module bit_file_section_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bfsp_in_if.sink           i_in,
    bfsp_out_if.source        o_res
);
    import bfsp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    in_fire;

    // Take a byte when the result slot is free or being emptied
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    bfsp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_in.data_byte),
        .i_eos    (i_in.end_of_stream),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    // Result channel
    assign o_res.valid           = r_out_valid;
    assign o_res.payload_byte    = r_res.payload_byte;
    assign o_res.payload_valid   = r_res.payload_valid;
    assign o_res.section_kind    = r_res.section_kind;
    assign o_res.section_end     = r_res.section_end;
    assign o_res.section_length  = r_res.section_length;
    assign o_res.length_valid    = r_res.length_valid;
    assign o_res.unknown_section = r_res.unknown_section;
    assign o_res.file_done       = r_res.file_done;
    assign o_res.status          = r_res.status;

endmodule

`default_nettype wire

// File: tb/bit_file_section_parser_tb.sv
// Testbench for bit_file_section_parser: drives bit files byte by byte and
// checks every result item against a built-in parser model or a fixed expected result.
// Depends on bfsp_pkg, bfsp_if and the parser RTL.
`timescale 1ns / 100ps

module bit_file_section_parser_tb;
    import bfsp_pkg::*;

    localparam int ITEM_TARGET = 600;
    localparam int CYCLE_LIMIT = 100000;

    // Fixed file header, first byte in the top bits
    localparam logic [103:0] SYNC_WORD = 104'h0009_0ff0_0ff0_0ff0_0ff0_0000_01;

    // One row of the directed part
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         fixed;
        t_result    res;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    bfsp_in_if  in_ch ();
    bfsp_out_if res_ch ();

    bit_file_section_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // Parser model state
    t_phase      parse_phase;
    logic [3:0]  hdr_pos;
    logic [2:0]  len_left;
    logic [2:0]  sec_kind;
    logic [31:0] sec_count;
    logic [4:0]  seen_mask;
    logic [1:0]  file_status;

    t_result pending_results[$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] sync_byte(input int idx);
        return SYNC_WORD[103 - 8 * idx -: 8];
    endfunction

    function automatic t_result status_only(input logic done, input logic [1:0] st);
        t_result r;
        r = '0;
        r.file_done = done;
        r.status = st;
        return r;
    endfunction

    function automatic void clear_parser();
        parse_phase = PH_HEADER;
        hdr_pos = '0;
        len_left = '0;
        sec_kind = '0;
        sec_count = '0;
        seen_mask = '0;
        file_status = ST_OK;
    endfunction

    // First error sticks; parser then ignores the rest of the file
    function automatic void flag_error(input logic [1:0] code);
        if (file_status == ST_OK) file_status = code;
        parse_phase = PH_ERROR;
    endfunction

    // Expected result for one byte; advances the parser model
    function automatic t_result parse_byte(input logic [7:0] b, input logic eos);
        t_result    r;
        logic [7:0] ofs;
        r = '0;
        if (parse_phase == PH_LENGTH || parse_phase == PH_PAYLOAD) begin
            r.section_kind = sec_kind;
            r.unknown_section = (sec_kind == KIND_UNKNOWN);
        end
        case (parse_phase)
            PH_HEADER: begin
                if (b != sync_byte(hdr_pos)) begin
                    flag_error(ST_HEADER);
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                    if (hdr_pos == HEADER_LEN) parse_phase = PH_ID;
                end
            end
            PH_ID: begin
                ofs = b - ID_FIRST;
                sec_kind = (b >= ID_FIRST && b <= ID_LAST) ? ofs[2:0] : KIND_UNKNOWN;
                if (sec_kind != KIND_UNKNOWN && seen_mask[sec_kind]) begin
                    flag_error(ST_DUPLICATE);
                end else begin
                    if (sec_kind != KIND_UNKNOWN) seen_mask[sec_kind] = 1'b1;
                    r.section_kind = sec_kind;
                    r.unknown_section = (sec_kind == KIND_UNKNOWN);
                    len_left = (sec_kind == KIND_BITSTREAM) ? LEN_BYTES_LONG : LEN_BYTES_SHORT;
                    sec_count = '0;
                    parse_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                // big-endian length assembly
                sec_count = {sec_count[23:0], b};
                if (len_left != 0) len_left = len_left - 3'd1;
                if (len_left == 0) begin
                    r.section_length = sec_count;
                    r.length_valid = 1'b1;
                    if (sec_count == 0) begin
                        r.section_end = 1'b1;
                        parse_phase = PH_ID;
                    end else begin
                        parse_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (sec_kind != KIND_UNKNOWN) begin
                    r.payload_byte = b;
                    r.payload_valid = 1'b1;
                end
                if (sec_count != 0) sec_count = sec_count - 32'd1;
                if (sec_count == 0) begin
                    r.section_end = 1'b1;
                    parse_phase = PH_ID;
                end
            end
            default: ;
        endcase
        // end of file: only a section or header boundary is a clean end
        if (eos) begin
            if (parse_phase != PH_ID && parse_phase != PH_ERROR) flag_error(ST_TRUNCATED);
            r.file_done = 1'b1;
        end
        r.status = file_status;
        if (eos) clear_parser();
        return r;
    endfunction

    // Offer one byte, hold it until taken, then queue its expected result
    task automatic push_byte(input logic [7:0] b, input logic eos, input bit fixed,
                             input t_result fixed_res);
        t_result predicted;
        while (!calm && $urandom_range(99) < 14) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = parse_byte(b, eos);
        pending_results.push_back(fixed ? fixed_res : predicted);
        bytes_sent++;
        calm = (bytes_sent >= 250 && bytes_sent < 420);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Build one random file and send it; most files are well formed
    task automatic emit_file();
        logic [7:0]  fbytes[$];
        logic [7:0]  id;
        logic [31:0] len_val;
        logic [4:0]  used;
        int          mode;
        int          n_sec;
        int          k;
        int          cut;
        bit          huge;
        mode = $urandom_range(99);
        used = '0;
        huge = 1'b0;
        if (mode < 5) begin
            // noise file
            repeat ($urandom_range(1, 20)) fbytes.push_back(8'($urandom_range(255)));
        end else begin
            for (int i = 0; i < 13; i++) fbytes.push_back(sync_byte(i));
            if (mode < 12) fbytes[$urandom_range(12)] = 8'($urandom_range(255));
            n_sec = $urandom_range(0, 6);
            for (int s = 0; s < n_sec; s++) begin
                if ($urandom_range(99) < 20) begin
                    id = 8'($urandom_range(255));
                end else begin
                    k = $urandom_range(4);
                    // mostly pick a kind not yet used; sometimes allow a repeat
                    if (used[k] && $urandom_range(9) != 0) begin
                        for (int j = 4; j >= 0; j--) if (!used[j]) k = j;
                    end
                    used[k] = 1'b1;
                    id = ID_FIRST + 8'(k);
                end
                mode = $urandom_range(99);
                if (mode < 8) begin
                    huge = 1'b1;
                    len_val = $urandom_range(1) ? 32'hffff_ffff : $urandom;
                end else if (mode < 20) begin
                    len_val = $urandom_range(6, 40);
                end else begin
                    len_val = $urandom_range(0, 5);
                end
                fbytes.push_back(id);
                if (id == ID_LAST) begin
                    fbytes.push_back(len_val[31:24]);
                    fbytes.push_back(len_val[23:16]);
                end
                fbytes.push_back(len_val[15:8]);
                fbytes.push_back(len_val[7:0]);
                // a huge section can only end by truncation
                if (huge) begin
                    repeat ($urandom_range(1, 5)) fbytes.push_back(8'($urandom_range(255)));
                    break;
                end
                repeat (len_val) fbytes.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(1, fbytes.size());
                while (fbytes.size() > cut) void'(fbytes.pop_back());
            end
        end
        foreach (fbytes[i]) push_byte(fbytes[i], i == fbytes.size() - 1, 1'b0, '0);
    endtask

    function automatic void cmp_field(input string fld, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual item with status %0h",
                         $time, res_ch.status);
            end else begin
                want = pending_results.pop_front();
                cmp_field("payload_byte", 32'(want.payload_byte),
                          32'(res_ch.payload_byte));
                cmp_field("payload_valid", 32'(want.payload_valid),
                          32'(res_ch.payload_valid));
                cmp_field("section_kind", 32'(want.section_kind),
                          32'(res_ch.section_kind));
                cmp_field("section_end", 32'(want.section_end),
                          32'(res_ch.section_end));
                cmp_field("section_length", want.section_length, res_ch.section_length);
                cmp_field("length_valid", 32'(want.length_valid),
                          32'(res_ch.length_valid));
                cmp_field("unknown_section", 32'(want.unknown_section),
                          32'(res_ch.unknown_section));
                cmp_field("file_done", 32'(want.file_done), 32'(res_ch.file_done));
                cmp_field("status", 32'(want.status), 32'(res_ch.status));
            end
        end
    end

    // Result side stalls
    initial res_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= 14);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence
    initial begin
        t_step plan[$];
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.end_of_stream = 1'b0;
        i_rst_n = 1'b0;
        clear_parser();

        // bad first header byte, then end of that file
        plan.push_back('{8'hff, 1'b0, 1'b1, status_only(1'b0, ST_HEADER)});
        plan.push_back('{8'h00, 1'b1, 1'b1, status_only(1'b1, ST_HEADER)});
        // good header, 'a' with two extreme payload bytes, empty 'e'
        for (int i = 0; i < 13; i++) plan.push_back('{sync_byte(i), 1'b0, 1'b0, '0});
        plan.push_back('{ID_FIRST, 1'b0, 1'b0, '0});
        plan.push_back('{8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{8'h02, 1'b0, 1'b0, '0});
        plan.push_back('{8'hff, 1'b0, 1'b0, '0});
        plan.push_back('{8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ID_LAST, 1'b0, 1'b0, '0});
        repeat (4) plan.push_back('{8'h00, 1'b0, 1'b0, '0});
        // repeated 'e' section, then end of file
        plan.push_back('{ID_LAST, 1'b0, 1'b1, status_only(1'b0, ST_DUPLICATE)});
        plan.push_back('{8'hff, 1'b1, 1'b1, status_only(1'b1, ST_DUPLICATE)});
        // file cut off inside the header
        plan.push_back('{8'h00, 1'b1, 1'b1, status_only(1'b1, ST_TRUNCATED)});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) push_byte(plan[i].data, plan[i].last, plan[i].fixed, plan[i].res);
        wait_drained();

        while (bytes_sent < ITEM_TARGET + plan.size()) begin
            emit_file();
            if ($urandom_range(19) == 0) wait_drained();
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bfsp_pkg.sv
rtl/bfsp_if.sv
rtl/bfsp_step.sv
rtl/bit_file_section_parser.sv
tb/bit_file_section_parser_tb.sv
